>>> hdl/lcs_pkg.sv
// Shared types and constants for the least-connections selector.
`timescale 1ns / 1ps

package lcs_pkg;

  // Fixed field widths of the ports.
  localparam int CFG_W     = 5;
  localparam int IDX_W     = 4;
  localparam int DELTA_W   = 17;
  localparam int CNT_OUT_W = 16;

  // Request codes.
  localparam logic REQ_PICK   = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK_INC,
    ST_UPD,
    ST_OUT
  } lcs_state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

>>> hdl/least_connections_selector.sv
// Least-connections selector: top level with the request sequencer.
// A pick walks the counters of the N active servers and then increments the least one, an update
// adds its delta to one counter, and an unmatched request goes straight to the result.
// A new request is taken only once the previous one has handed its result to the output register,
// and the single shared adder reads one counter a cycle through the memory's read port.
// Reset clears the server count and marks every counter as zero at once.
`timescale 1ns / 1ps

module least_connections_selector #(
  parameter int MAX_SERVERS = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_num_servers_we,
  input  logic [lcs_pkg::CFG_W-1:0]     cfg_num_servers,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [lcs_pkg::IDX_W-1:0]     in_server_index,
  input  logic signed [lcs_pkg::DELTA_W-1:0] in_delta,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic [lcs_pkg::IDX_W-1:0]     out_result_index,
  output logic [lcs_pkg::CNT_OUT_W-1:0] out_new_count
);

  import lcs_pkg::*;

  localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int NW = $clog2(MAX_SERVERS + 1);
  localparam int CW = (NW > CFG_W) ? NW : CFG_W;
  localparam int SW = ((COUNT_WIDTH > DELTA_W) ? COUNT_WIDTH : DELTA_W) + 2;

  lcs_state_t state_r, state_nxt;
  logic [CFG_W-1:0] num_servers_r;
  logic [CW-1:0] n_act;
  logic [CW-1:0] num_ext;
  logic [CW-1:0] idx_ext;
  logic [CW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cmp_ptr_r, cmp_ptr_nxt;
  logic [COUNT_WIDTH-1:0] best_cnt_r, best_cnt_nxt;
  logic [AW-1:0] best_idx_r, best_idx_nxt;
  logic [DELTA_W-1:0] delta_r, delta_nxt;
  logic res_found_r, res_found_nxt;
  logic [IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic [CNT_OUT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_found_r, out_found_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [CNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic [31:0] idx32;
  logic [31:0] cnt32;

  logic mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [COUNT_WIDTH-1:0] mem_rd_data;
  logic mem_wr_en;
  logic [COUNT_WIDTH-1:0] mem_wr_data;

  alu_op_t alu_op;
  logic [COUNT_WIDTH-1:0] alu_a;
  logic [SW-1:0] alu_b;
  logic alu_neg;
  logic [COUNT_WIDTH-1:0] alu_res;

  lcs_count_mem #(
    .DEPTH (MAX_SERVERS),
    .AW    (AW),
    .DW    (COUNT_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (best_idx_r),
    .wr_data (mem_wr_data)
  );

  lcs_alu #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .neg (alu_neg),
    .res (alu_res)
  );

  // A register value above the memory depth acts as the full depth.
  assign num_ext = CW'(num_servers_r);
  assign n_act   = (num_ext > CW'(MAX_SERVERS)) ? CW'(MAX_SERVERS) : num_ext;
  assign idx_ext = CW'(in_server_index);
  assign idx32   = 32'(best_idx_r);
  assign cnt32   = 32'(alu_res);
  assign mem_wr_data = alu_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      num_servers_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_num_servers_we) begin
        num_servers_r <= cfg_num_servers;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r    <= rd_ptr_nxt;
    cmp_ptr_r   <= cmp_ptr_nxt;
    best_cnt_r  <= best_cnt_nxt;
    best_idx_r  <= best_idx_nxt;
    delta_r     <= delta_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    res_cnt_r   <= res_cnt_nxt;
    out_found_r <= out_found_nxt;
    out_idx_r   <= out_idx_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    rd_ptr_nxt    = rd_ptr_r;
    cmp_ptr_nxt   = cmp_ptr_r;
    best_cnt_nxt  = best_cnt_r;
    best_idx_nxt  = best_idx_r;
    delta_nxt     = delta_r;
    res_found_nxt = res_found_r;
    res_idx_nxt   = res_idx_r;
    res_cnt_nxt   = res_cnt_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_idx_nxt   = out_idx_r;
    out_cnt_nxt   = out_cnt_r;
    in_ready      = 1'b0;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = '0;
    mem_wr_en     = 1'b0;
    alu_op        = ALU_SUB;
    alu_a         = mem_rd_data;
    alu_b         = {{(SW-COUNT_WIDTH){1'b0}}, best_cnt_r};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type == REQ_PICK) begin
            if (n_act == '0) begin
              res_found_nxt = 1'b0;
              res_idx_nxt   = '0;
              res_cnt_nxt   = '0;
              state_nxt     = ST_OUT;
            end else begin
              mem_rd_en    = 1'b1;
              mem_rd_addr  = '0;
              rd_ptr_nxt   = CW'(1);
              cmp_ptr_nxt  = '0;
              best_cnt_nxt = '1;
              best_idx_nxt = '0;
              state_nxt    = ST_SCAN;
            end
          end else begin
            if (idx_ext >= n_act) begin
              res_found_nxt = 1'b0;
              res_idx_nxt   = '0;
              res_cnt_nxt   = '0;
              state_nxt     = ST_OUT;
            end else begin
              mem_rd_en    = 1'b1;
              mem_rd_addr  = idx_ext[AW-1:0];
              best_idx_nxt = idx_ext[AW-1:0];
              delta_nxt    = in_delta;
              state_nxt    = ST_UPD;
            end
          end
        end
      end
      ST_SCAN: begin
        // Strictly-less keeps the lowest index on a tie.
        if (alu_neg) begin
          best_cnt_nxt = mem_rd_data;
          best_idx_nxt = cmp_ptr_r[AW-1:0];
        end
        if (rd_ptr_r < n_act) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = rd_ptr_r[AW-1:0];
          rd_ptr_nxt  = rd_ptr_r + CW'(1);
        end
        if (cmp_ptr_r == (n_act - CW'(1))) begin
          state_nxt = ST_PICK_INC;
        end else begin
          cmp_ptr_nxt = cmp_ptr_r + CW'(1);
        end
      end
      ST_PICK_INC: begin
        alu_op        = ALU_ADD;
        alu_a         = best_cnt_r;
        alu_b         = SW'(1);
        mem_wr_en     = 1'b1;
        res_found_nxt = 1'b1;
        res_idx_nxt   = idx32[IDX_W-1:0];
        res_cnt_nxt   = cnt32[CNT_OUT_W-1:0];
        state_nxt     = ST_OUT;
      end
      ST_UPD: begin
        alu_op        = ALU_ADD;
        alu_a         = mem_rd_data;
        alu_b         = {{(SW-DELTA_W){delta_r[DELTA_W-1]}}, delta_r};
        mem_wr_en     = 1'b1;
        res_found_nxt = 1'b1;
        res_idx_nxt   = idx32[IDX_W-1:0];
        res_cnt_nxt   = cnt32[CNT_OUT_W-1:0];
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_idx_nxt   = res_idx_r;
          out_cnt_nxt   = res_cnt_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_result_index = out_idx_r;
  assign out_new_count    = out_cnt_r;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_result_index == '0 && out_new_count == '0)
    else $error("unmatched result carries nonzero payload");

  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> state_r == ST_PICK_INC || state_r == ST_UPD)
    else $error("counter written outside an update step");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> cmp_ptr_r < n_act)
    else $error("scan pointer beyond active servers");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

endmodule

>>> hdl/lcs_count_mem.sv
// Connection counter memory with per-entry valid bits and a registered read port.
`timescale 1ns / 1ps

module lcs_count_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DW-1:0] rd_q_r;
  logic rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r   <= mem[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

>>> hdl/lcs_alu.sv
// Shared adder used for counter compares and clamped counter updates.
`timescale 1ns / 1ps

module lcs_alu #(
  parameter int COUNT_WIDTH = 16,
  localparam int SW = ((COUNT_WIDTH > lcs_pkg::DELTA_W) ? COUNT_WIDTH : lcs_pkg::DELTA_W) + 2
) (
  input  lcs_pkg::alu_op_t        op,
  input  logic [COUNT_WIDTH-1:0]  a,
  input  logic [SW-1:0]           b,
  output logic                    neg,
  output logic [COUNT_WIDTH-1:0]  res
);

  import lcs_pkg::*;

  logic [SW-1:0] a_ext;
  logic [SW-1:0] b_op;
  logic [SW-1:0] sum;
  logic over;

  assign a_ext = {{(SW-COUNT_WIDTH){1'b0}}, a};
  assign b_op  = (op == ALU_SUB) ? ~b : b;
  assign sum   = a_ext + b_op + {{(SW-1){1'b0}}, (op == ALU_SUB)};
  assign neg   = sum[SW-1];
  assign over  = !sum[SW-1] && (|sum[SW-2:COUNT_WIDTH]);

  // Clamp to zero below and to the counter maximum above.
  always_comb begin
    if (neg) begin
      res = '0;
    end else if (over) begin
      res = '1;
    end else begin
      res = sum[COUNT_WIDTH-1:0];
    end
  end

endmodule

>>> tb/least_connections_selector_tb.sv
// Self-checking testbench for the least-connections selector.
`timescale 1ns / 1ps

module least_connections_selector_tb;
  import lcs_pkg::*;

  localparam int MAX_SERVERS = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int COUNT_MAX = (1 << COUNT_WIDTH) - 1;
  localparam int SETTLE_CYCLES = 25;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 125;

  typedef struct packed {
    logic                 found;
    logic [IDX_W-1:0]     index;
    logic [CNT_OUT_W-1:0] count;
  } reply_t;

  class selector_scoreboard;
    logic [COUNT_WIDTH-1:0] load[MAX_SERVERS];
    logic [CFG_W-1:0]       server_cfg;
    reply_t                 pending_replies[$];
    int                     errors;

    function new();
      foreach (load[i]) load[i] = '0;
      server_cfg = '0;
      errors = 0;
    endfunction

    function void set_servers(logic [CFG_W-1:0] value);
      server_cfg = value;
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    // Works out the reply to one accepted request and updates the counters.
    function void note_request(logic req, logic [IDX_W-1:0] idx,
                               logic signed [DELTA_W-1:0] delta);
      int active;
      int best;
      int sum;
      reply_t r;
      active = (server_cfg > MAX_SERVERS) ? MAX_SERVERS : int'(server_cfg);
      r = '0;
      if (req == REQ_PICK) begin
        if (active != 0) begin
          best = 0;
          for (int i = 1; i < active; i++) begin
            if (load[i] < load[best]) best = i;
          end
          if (load[best] != COUNT_MAX[COUNT_WIDTH-1:0]) load[best] = load[best] + 1'b1;
          r.found = 1'b1;
          r.index = best[IDX_W-1:0];
          r.count = load[best][CNT_OUT_W-1:0];
        end
      end else if (int'(idx) < active) begin
        sum = int'(load[idx]) + int'(delta);
        if (sum < 0) sum = 0;
        if (sum > COUNT_MAX) sum = COUNT_MAX;
        load[idx] = sum[COUNT_WIDTH-1:0];
        r.found = 1'b1;
        r.index = idx;
        r.count = load[idx][CNT_OUT_W-1:0];
      end
      pending_replies = {pending_replies, r};
    endfunction

    function void check_reply(logic found, logic [IDX_W-1:0] idx,
                              logic [CNT_OUT_W-1:0] count);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: found %0d, index %0d, count %0d", found, idx, count);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, found);
        errors++;
      end
      if (idx !== want.index) begin
        $error("result_index: expected %0d, actual %0d", want.index, idx);
        errors++;
      end
      if (count !== want.count) begin
        $error("new_count: expected %0d, actual %0d", want.count, count);
        errors++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      cfg_num_servers_we = 1'b0;
  logic [CFG_W-1:0]          cfg_num_servers = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_req_type = REQ_PICK;
  logic [IDX_W-1:0]          in_server_index = '0;
  logic signed [DELTA_W-1:0] in_delta = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      out_found;
  logic [IDX_W-1:0]          out_result_index;
  logic [CNT_OUT_W-1:0]      out_new_count;

  selector_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  logic [CFG_W-1:0] cur_cfg = '0;

  least_connections_selector #(
    .MAX_SERVERS(MAX_SERVERS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_num_servers_we (cfg_num_servers_we),
    .cfg_num_servers    (cfg_num_servers),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_server_index    (in_server_index),
    .in_delta           (in_delta),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found          (out_found),
    .out_result_index   (out_result_index),
    .out_new_count      (out_new_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Both channels are sampled at the edge, before any of its updates land.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_reply(out_found, out_result_index, out_new_count);
    end
    if (rst_n && in_valid && in_ready) begin
      sb.note_request(in_req_type, in_server_index, in_delta);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("least_connections_selector_tb: errors");
    $finish;
  end

  // Returns at the edge where the request transfer happens.
  task automatic send_request(logic req, logic [IDX_W-1:0] idx,
                              logic signed [DELTA_W-1:0] delta);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_server_index <= idx;
    in_delta <= delta;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // The register is only written once every reply is back and the block is idle.
  task automatic write_servers(logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    // Let the monitor record the last transfer before counting what is pending.
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_num_servers_we <= 1'b1;
    cfg_num_servers <= value;
    sb.set_servers(value);
    cur_cfg = value;
    @(posedge clk);
    cfg_num_servers_we <= 1'b0;
  endtask

  task automatic random_request();
    int active;
    int pick;
    logic [IDX_W-1:0] idx;
    logic signed [DELTA_W-1:0] delta;
    active = (cur_cfg > MAX_SERVERS) ? MAX_SERVERS : int'(cur_cfg);
    pick = $urandom_range(99);
    delta = DELTA_W'($urandom);
    idx = IDX_W'($urandom);
    if (pick < 50) begin
      send_request(REQ_PICK, idx, delta);
    end else begin
      // Mostly target live servers so counters move; some land out of range.
      if (active > 0 && $urandom_range(9) < 8) idx = IDX_W'($urandom_range(active - 1));
      pick = $urandom_range(99);
      if (pick < 60) delta = DELTA_W'(int'($urandom_range(16)) - 8);
      else if (pick < 75) delta = $urandom_range(1) ? 17'sh0FFFF : 17'sh10000;
      else if (pick < 85) delta = -$signed({1'b0, 16'($urandom)});
      send_request(REQ_UPDATE, idx, delta);
    end
  endtask

  initial begin
    int send_tbl[4];
    int recv_tbl[4];
    logic [CFG_W-1:0] cfg_tbl[PHASES];
    send_tbl = '{0, 55, 0, 26};
    recv_tbl = '{0, 0, 55, 26};
    cfg_tbl = '{5'd16, 5'd31, 5'd1, 5'd5, 5'd17, 5'd0, 5'd16, 5'd0};
    cfg_tbl[PHASES-1] = CFG_W'($urandom);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Nothing configured yet: every request comes back not found.
    send_request(REQ_PICK, 4'd0, 17'sd0);
    send_request(REQ_UPDATE, 4'd0, 17'sd5);

    // Ties go to the lowest index, then saturation, clamping and range checks.
    write_servers(5'd4);
    repeat (5) send_request(REQ_PICK, 4'd9, 17'sh1FFFF);
    send_request(REQ_UPDATE, 4'd2, 17'sh0FFFF);
    send_request(REQ_UPDATE, 4'd1, 17'sh10000);
    send_request(REQ_UPDATE, 4'd4, 17'sd1);
    send_request(REQ_UPDATE, 4'd15, -17'sd1);
    send_request(REQ_PICK, 4'd0, 17'sd0);

    // A single server at the counter maximum stays there on a pick.
    write_servers(5'd1);
    send_request(REQ_UPDATE, 4'd0, 17'sh0FFFF);
    send_request(REQ_PICK, 4'd0, 17'sd0);
    send_request(REQ_PICK, 4'd15, 17'sh15555);

    // A register value above the maximum acts as the full server set.
    write_servers(5'd31);
    send_request(REQ_UPDATE, 4'd15, 17'sh0AAAA);
    send_request(REQ_PICK, 4'd0, 17'sd0);
    send_request(REQ_UPDATE, 4'd15, 17'sh15555);

    // Shrinking and growing again must leave the counters untouched.
    write_servers(5'd2);
    send_request(REQ_PICK, 4'd0, 17'sd0);
    send_request(REQ_UPDATE, 4'd2, 17'sd1);
    write_servers(5'd16);
    send_request(REQ_UPDATE, 4'd2, 17'sd0);

    for (int p = 0; p < PHASES; p++) begin
      write_servers(cfg_tbl[p]);
      send_idle_pct = send_tbl[p % 4];
      recv_stall_pct = recv_tbl[p % 4];
      repeat (ITEMS_PER_PHASE) random_request();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("least_connections_selector_tb: clean");
    end else begin
      $display("least_connections_selector_tb: errors");
    end
    $finish;
  end

endmodule

>>> least_connections_selector.f
hdl/lcs_pkg.sv
hdl/lcs_count_mem.sv
hdl/lcs_alu.sv
hdl/least_connections_selector.sv
tb/least_connections_selector_tb.sv
